@@ rtl/core/i2c_master_bit_engine_core_macros.svh @@
// Assertion macros used by the checker file.
`ifndef I2C_MASTER_BIT_ENGINE_CORE_MACROS_SVH
`define I2C_MASTER_BIT_ENGINE_CORE_MACROS_SVH

// A property checked only while reset is low.
`define I2CM_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("i2cm assertion failed");

// A property that is checked during reset as well.
`define I2CM_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("i2cm assertion failed");

`endif

@@ rtl/core/i2cm_pkg.sv @@
package i2cm_pkg;

  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP  = 3'd2;
  localparam logic [2:0] CMD_WRITE = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NACK    = 2'd1;
  localparam logic [1:0] ST_BUS     = 2'd2;
  localparam logic [1:0] ST_TIMEOUT = 2'd3;

  localparam logic [0:0] REG_HALF_PERIOD    = 1'b0;
  localparam logic [0:0] REG_STRETCH_LIMIT  = 1'b1;

  localparam logic [15:0] HALF_PERIOD_RESET   = 16'd5;
  localparam logic [15:0] STRETCH_LIMIT_RESET = 16'd1000;

  localparam int BITS_PER_BYTE = 8;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       scl_in;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_low;
    logic       sda_low;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
    logic [7:0] rx_byte;
  } out_item_t;

  typedef struct packed {
    logic       we;
    logic [0:0] index;
    logic [15:0] data;
  } cfg_write_t;

endpackage

@@ rtl/core/i2c_master_bit_engine_core.sv @@
// A tick beat's result passes through the input register, then the sequencer
// update into the result register. Throughput: one tick beat per cycle unless
// out_ready stalls the output; the sequencer state updates once per beat.
// Reset (synchronous, active high) idles the sequencer, releases both lines,
// clears status and received byte, and restores the default timing registers.
module i2c_master_bit_engine_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  i2cm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output i2cm_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  logic                 advance;
  logic                 hold_valid;
  i2cm_pkg::in_item_t   hold_data;
  i2cm_pkg::out_item_t  result;
  i2cm_pkg::cfg_write_t cfg;

  assign advance = !out_valid || out_ready;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  i2cm_in_reg u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .advance   (advance),
    .hold_valid(hold_valid),
    .hold_data (hold_data)
  );

  i2cm_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .step  (hold_valid && advance),
    .item  (hold_data),
    .cfg   (cfg),
    .result(result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= hold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && hold_valid) begin
      out_data <= result;
    end
  end

endmodule

@@ rtl/core/i2cm_in_reg.sv @@
module i2cm_in_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  i2cm_pkg::in_item_t in_data,
  input  logic               advance,
  output logic               hold_valid,
  output i2cm_pkg::in_item_t hold_data
);

  assign in_ready = !hold_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      hold_data <= in_data;
    end
  end

endmodule

@@ rtl/core/i2cm_seq.sv @@
module i2cm_seq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  i2cm_pkg::in_item_t   item,
  input  i2cm_pkg::cfg_write_t cfg,
  output i2cm_pkg::out_item_t  result
);

  localparam logic [4:0] PH_IDLE     = 5'd0;
  localparam logic [4:0] PH_WAIT_SCL = 5'd1;
  localparam logic [4:0] PH_HIGH_DLY = 5'd2;
  localparam logic [4:0] PH_ST_D1    = 5'd3;
  localparam logic [4:0] PH_ST_D2    = 5'd4;
  localparam logic [4:0] PH_SP_D1    = 5'd5;
  localparam logic [4:0] PH_SP_D2    = 5'd6;
  localparam logic [4:0] PH_WR_D1    = 5'd7;
  localparam logic [4:0] PH_WR_D2    = 5'd8;
  localparam logic [4:0] PH_WR_AD1   = 5'd9;
  localparam logic [4:0] PH_WR_AD2   = 5'd10;
  localparam logic [4:0] PH_RD_D     = 5'd11;
  localparam logic [4:0] PH_RD_AD1   = 5'd12;
  localparam logic [4:0] PH_RD_AD2   = 5'd13;

  localparam logic [3:0] BYTE_BITS = 4'(i2cm_pkg::BITS_PER_BYTE);

  logic [15:0] half_period_ticks;
  logic [15:0] stretch_timeout_ticks;

  logic [4:0]  phase, phase_next;
  logic [2:0]  active_command, active_command_next;
  logic [15:0] half_period_timer, half_period_timer_next;
  logic [15:0] stretch_counter, stretch_counter_next;
  logic [3:0]  bit_counter, bit_counter_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic        ack_flag, ack_flag_next;
  logic        scl_drive, scl_drive_next;
  logic        sda_drive, sda_drive_next;
  logic [1:0]  last_status, last_status_next;
  logic [7:0]  rx_hold, rx_hold_next;
  logic        done_next;
  logic [15:0] delay_load;
  logic        timer_end;

  assign delay_load = (half_period_ticks == 16'd0) ? 16'd1 : half_period_ticks;
  assign timer_end  = (half_period_timer <= 16'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period_ticks     <= i2cm_pkg::HALF_PERIOD_RESET;
      stretch_timeout_ticks <= i2cm_pkg::STRETCH_LIMIT_RESET;
    end else if (cfg.we) begin
      unique case (cfg.index)
        i2cm_pkg::REG_HALF_PERIOD:   half_period_ticks     <= cfg.data;
        i2cm_pkg::REG_STRETCH_LIMIT: stretch_timeout_ticks <= cfg.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_next             = phase;
    active_command_next    = active_command;
    half_period_timer_next = half_period_timer;
    stretch_counter_next   = stretch_counter;
    bit_counter_next       = bit_counter;
    shift_byte_next        = shift_byte;
    ack_flag_next          = ack_flag;
    scl_drive_next         = scl_drive;
    sda_drive_next         = sda_drive;
    last_status_next       = last_status;
    rx_hold_next           = rx_hold;
    done_next              = 1'b0;

    unique case (phase)
      PH_IDLE: begin
        if (item.cmd == i2cm_pkg::CMD_START) begin
          active_command_next  = item.cmd;
          sda_drive_next       = 1'b0;
          scl_drive_next       = 1'b0;
          stretch_counter_next = 16'd0;
          phase_next           = PH_WAIT_SCL;
        end else if (item.cmd == i2cm_pkg::CMD_STOP) begin
          active_command_next    = item.cmd;
          sda_drive_next         = 1'b1;
          half_period_timer_next = delay_load;
          phase_next             = PH_SP_D1;
        end else if (item.cmd == i2cm_pkg::CMD_WRITE) begin
          active_command_next    = item.cmd;
          shift_byte_next        = item.tx_byte;
          bit_counter_next       = 4'd0;
          sda_drive_next         = !item.tx_byte[7];
          half_period_timer_next = delay_load;
          phase_next             = PH_WR_D1;
        end else if (item.cmd == i2cm_pkg::CMD_READ) begin
          active_command_next  = item.cmd;
          sda_drive_next       = 1'b0;
          shift_byte_next      = 8'd0;
          bit_counter_next     = 4'd0;
          ack_flag_next        = item.send_ack;
          scl_drive_next       = 1'b0;
          stretch_counter_next = 16'd0;
          phase_next           = PH_WAIT_SCL;
        end
      end
      PH_WAIT_SCL: begin
        if (item.scl_in) begin
          half_period_timer_next = delay_load;
          phase_next             = PH_HIGH_DLY;
        end else if (stretch_counter >= stretch_timeout_ticks) begin
          if (active_command == i2cm_pkg::CMD_READ && bit_counter >= BYTE_BITS) begin
            sda_drive_next = 1'b0;
          end
          last_status_next    = i2cm_pkg::ST_TIMEOUT;
          phase_next          = PH_IDLE;
          active_command_next = i2cm_pkg::CMD_NONE;
          done_next           = 1'b1;
        end else begin
          stretch_counter_next = stretch_counter + 16'd1;
        end
      end
      PH_HIGH_DLY: begin
        if (!timer_end) begin
          half_period_timer_next = half_period_timer - 16'd1;
        end else if (active_command == i2cm_pkg::CMD_START && item.sda_in) begin
          sda_drive_next         = 1'b1;
          half_period_timer_next = delay_load;
          phase_next             = PH_ST_D1;
        end else if (active_command == i2cm_pkg::CMD_STOP) begin
          sda_drive_next         = 1'b0;
          half_period_timer_next = delay_load;
          phase_next             = PH_SP_D2;
        end else if (active_command == i2cm_pkg::CMD_WRITE) begin
          scl_drive_next         = 1'b1;
          half_period_timer_next = delay_load;
          if (bit_counter < BYTE_BITS) begin
            shift_byte_next  = {shift_byte[6:0], 1'b0};
            bit_counter_next = bit_counter + 4'd1;
            phase_next       = PH_WR_D2;
          end else begin
            ack_flag_next = item.sda_in;
            phase_next    = PH_WR_AD2;
          end
        end else if (active_command == i2cm_pkg::CMD_READ) begin
          scl_drive_next         = 1'b1;
          half_period_timer_next = delay_load;
          if (bit_counter < BYTE_BITS) begin
            shift_byte_next  = {shift_byte[6:0], item.sda_in};
            bit_counter_next = bit_counter + 4'd1;
            phase_next       = PH_RD_D;
          end else begin
            sda_drive_next = 1'b0;
            phase_next     = PH_RD_AD2;
          end
        end else begin
          // Start that finds SDA held low, or no command at all.
          last_status_next    = i2cm_pkg::ST_BUS;
          phase_next          = PH_IDLE;
          active_command_next = i2cm_pkg::CMD_NONE;
          done_next           = 1'b1;
        end
      end
      PH_ST_D1, PH_ST_D2, PH_SP_D1, PH_SP_D2, PH_WR_D1, PH_WR_D2,
      PH_WR_AD1, PH_WR_AD2, PH_RD_D, PH_RD_AD1, PH_RD_AD2: begin
        if (!timer_end) begin
          half_period_timer_next = half_period_timer - 16'd1;
        end else if (phase == PH_ST_D1) begin
          scl_drive_next         = 1'b1;
          half_period_timer_next = delay_load;
          phase_next             = PH_ST_D2;
        end else if (phase == PH_SP_D1 || phase == PH_WR_D1 || phase == PH_WR_AD1 ||
                     phase == PH_RD_AD1 || (phase == PH_RD_D && bit_counter < BYTE_BITS)) begin
          scl_drive_next       = 1'b0;
          stretch_counter_next = 16'd0;
          phase_next           = PH_WAIT_SCL;
        end else if (phase == PH_WR_D2) begin
          half_period_timer_next = delay_load;
          if (bit_counter < BYTE_BITS) begin
            sda_drive_next = !shift_byte[7];
            phase_next     = PH_WR_D1;
          end else begin
            sda_drive_next = 1'b0;
            phase_next     = PH_WR_AD1;
          end
        end else if (phase == PH_RD_D) begin
          sda_drive_next         = ack_flag;
          half_period_timer_next = delay_load;
          phase_next             = PH_RD_AD1;
        end else begin
          if (phase == PH_ST_D2) begin
            last_status_next = i2cm_pkg::ST_OK;
          end else if (phase == PH_SP_D2) begin
            last_status_next = item.sda_in ? i2cm_pkg::ST_OK : i2cm_pkg::ST_BUS;
          end else if (phase == PH_WR_AD2) begin
            last_status_next = ack_flag ? i2cm_pkg::ST_NACK : i2cm_pkg::ST_OK;
          end else begin
            rx_hold_next     = shift_byte;
            last_status_next = i2cm_pkg::ST_OK;
          end
          phase_next          = PH_IDLE;
          active_command_next = i2cm_pkg::CMD_NONE;
          done_next           = 1'b1;
        end
      end
      default: begin
        last_status_next    = i2cm_pkg::ST_BUS;
        phase_next          = PH_IDLE;
        active_command_next = i2cm_pkg::CMD_NONE;
        done_next           = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_IDLE;
      active_command    <= i2cm_pkg::CMD_NONE;
      half_period_timer <= 16'd0;
      stretch_counter   <= 16'd0;
      bit_counter       <= 4'd0;
      shift_byte        <= 8'd0;
      ack_flag          <= 1'b0;
      scl_drive         <= 1'b0;
      sda_drive         <= 1'b0;
      last_status       <= i2cm_pkg::ST_OK;
      rx_hold           <= 8'd0;
    end else if (step) begin
      phase             <= phase_next;
      active_command    <= active_command_next;
      half_period_timer <= half_period_timer_next;
      stretch_counter   <= stretch_counter_next;
      bit_counter       <= bit_counter_next;
      shift_byte        <= shift_byte_next;
      ack_flag          <= ack_flag_next;
      scl_drive         <= scl_drive_next;
      sda_drive         <= sda_drive_next;
      last_status       <= last_status_next;
      rx_hold           <= rx_hold_next;
    end
  end

  always_comb begin
    result.scl_low  = scl_drive_next;
    result.sda_low  = sda_drive_next;
    result.busy_res = (phase_next != PH_IDLE);
    result.done_res = done_next;
    result.status   = last_status_next;
    result.rx_byte  = rx_hold_next;
  end

endmodule

@@ rtl/core/i2cm_checker.sv @@
`include "i2c_master_bit_engine_core_macros.svh"

module i2cm_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input i2cm_pkg::out_item_t out_data
);

  `I2CM_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_data))
  `I2CM_ASSERT(a_done_idle, clk, rst, out_valid && out_data.done_res |-> !out_data.busy_res)
  `I2CM_ASSERT(a_ready_when_empty, clk, rst, !out_valid |-> in_ready)
  `I2CM_ASSERT_RST(a_reset_empty, clk, $past(rst) |-> !out_valid)

endmodule

bind i2c_master_bit_engine_core i2cm_checker u_i2cm_checker (
  .clk      (clk),
  .rst      (rst),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
